// ----- rtl/ovm_pkg.sv -----
// ----------------------------------------------------------------------------
// ovm_pkg
// shared constants for the overlap voxel merge block: field widths, default
// sizes and merge mode codes
// ----------------------------------------------------------------------------
`default_nettype none

package ovm_pkg;

    localparam int DATA_W          = 16;
    localparam int CONTRIB_W       = 4;
    localparam int MODE_W          = 3;
    localparam int OUT_TDATA_W     = 24;
    localparam int OUT_PAD_W       = OUT_TDATA_W - DATA_W - CONTRIB_W;

    localparam int DEF_MAX_TILES   = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/ovm_store.sv -----
// ----------------------------------------------------------------------------
// ovm_store
// sample memory: one write port, two synchronous read ports; each read port
// registers its data, adding read latency
// ----------------------------------------------------------------------------
`default_nettype none

module ovm_store #(
    parameter int DEPTH = 8,
    parameter int DW    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output      logic [DW-1:0]            o_rdata0,
    output      logic [DW-1:0]            o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

// ----- rtl/ovm_div.sv -----
// ----------------------------------------------------------------------------
// ovm_div
// restoring divider, one quotient bit per cycle, done pulses once the last quotient bit is formed
// ----------------------------------------------------------------------------
`default_nettype none

module ovm_div #(
    parameter int NW = 19,
    parameter int DW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output      logic          o_done,
    output      logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_done;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {r_rem, r_quot[NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NW-2:0], ge};
            r_rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- rtl/overlap_voxel_merge.sv -----
// ----------------------------------------------------------------------------
// overlap_voxel_merge: one sample per cycle; intake stalls from the closing
// transfer until the result loads; first, min and max pass S_FIN and S_DONE,
// mean adds a serial divide (S_DIV), median a rank sweep over the kept samples (S_MED, S_MAVG)
// synchronous active-low reset clears mode, accumulators and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_voxel_merge #(
    parameter int MAX_TILES   = ovm_pkg::DEF_MAX_TILES,
    parameter int SAMPLE_BITS = ovm_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output      logic                             o_s_axis_tready,
    input  wire logic [ovm_pkg::DATA_W-1:0]       i_s_axis_tdata,  // sample_value
    input  wire logic                             i_s_axis_tlast,  // last_of_voxel
    output      logic                             o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // merged_value, contributors, zero pad
    output      logic [ovm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output      logic                             o_m_axis_tuser,  // overflowed
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [ovm_pkg::MODE_W-1:0]       i_cfg_data       // merge_mode
);

    import ovm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_TILES);
    localparam int CNT_W = $clog2(MAX_TILES + 1);
    localparam int SUM_W = SB + $clog2(MAX_TILES);

    localparam logic [2:0] S_COLL = 3'd0;
    localparam logic [2:0] S_FIN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MED  = 3'd3;
    localparam logic [2:0] S_MAVG = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // control
    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_drop, n_drop;
    logic              r_out_valid, n_out_valid;
    logic              r_issue, n_issue;
    logic              r_p_valid, n_p_valid;

    // payload
    logic [SB-1:0]     r_min, n_min;
    logic [SB-1:0]     r_max, n_max;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SB-1:0]     r_lastv, n_lastv;
    logic [SB-1:0]     r_res, n_res;
    logic [AW-1:0]     r_ci, n_ci;
    logic [AW-1:0]     r_cj, n_cj;
    logic              r_p_first, n_p_first;
    logic              r_p_endj, n_p_endj;
    logic              r_p_endall, n_p_endall;
    logic [CNT_W-1:0]  r_lt, n_lt;
    logic [CNT_W-1:0]  r_le, n_le;
    logic [SB-1:0]     r_lo, n_lo;
    logic [SB-1:0]     r_hi, n_hi;
    logic [DATA_W-1:0]    r_out_value, n_out_value;
    logic [CONTRIB_W-1:0] r_out_contrib, n_out_contrib;
    logic                 r_out_ovf, n_out_ovf;

    logic              in_xfer;
    logic [SB-1:0]     sample;
    logic              keep;
    logic              wr_en;
    logic [SB-1:0]     rd0, rd1;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic [CNT_W-1:0]  nm1;
    logic [AW-1:0]     nlast;
    logic [CNT_W-1:0]  klo, khi;
    logic [CNT_W-1:0]  lt_acc, le_acc;
    logic [SB:0]       mid_sum;

    assign o_s_axis_tready = (r_state == S_COLL);
    assign o_cfg_ready     = 1'b1;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign sample          = SB'(i_s_axis_tdata);
    assign keep            = r_count < CNT_W'(MAX_TILES);
    assign wr_en           = in_xfer && keep;
    assign nm1             = r_count - 1'b1;
    assign nlast           = nm1[AW-1:0];
    assign klo             = nm1 >> 1;
    assign khi             = r_count >> 1;
    assign mid_sum         = {1'b0, r_lo} + {1'b0, r_hi};
    assign div_start       = (r_state == S_FIN) && (r_mode == MODE_MEAN);

    ovm_store #(
        .DEPTH (MAX_TILES),
        .DW    (SB)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (wr_en),
        .i_waddr  (r_count[AW-1:0]),
        .i_wdata  (sample),
        .i_raddr0 (r_ci),
        .i_raddr1 (r_cj),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    ovm_div #(
        .NW (SUM_W),
        .DW (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        lt_acc = (r_p_first ? '0 : r_lt) + CNT_W'(rd1 < rd0);
        le_acc = (r_p_first ? '0 : r_le) + CNT_W'(rd1 <= rd0);
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_drop        = r_drop;
        n_out_valid   = r_out_valid;
        n_issue       = r_issue;
        n_p_valid     = 1'b0;
        n_min         = r_min;
        n_max         = r_max;
        n_sum         = r_sum;
        n_lastv       = r_lastv;
        n_res         = r_res;
        n_ci          = r_ci;
        n_cj          = r_cj;
        n_p_first     = r_p_first;
        n_p_endj      = r_p_endj;
        n_p_endall    = r_p_endall;
        n_lt          = r_lt;
        n_le          = r_le;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_out_value   = r_out_value;
        n_out_contrib = r_out_contrib;
        n_out_ovf     = r_out_ovf;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_COLL: begin
                if (in_xfer) begin
                    if (keep) begin
                        n_count = r_count + 1'b1;
                        n_lastv = sample;
                        n_sum   = r_sum + SUM_W'(sample);
                        if (sample < r_min) begin
                            n_min = sample;
                        end
                        if (sample > r_max) begin
                            n_max = sample;
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                case (r_mode)
                    MODE_MIN: begin
                        n_res   = r_min;
                        n_state = S_DONE;
                    end
                    MODE_MAX: begin
                        n_res   = r_max;
                        n_state = S_DONE;
                    end
                    MODE_MEAN: begin
                        n_state = S_DIV;
                    end
                    MODE_MEDIAN: begin
                        n_ci    = '0;
                        n_cj    = '0;
                        n_issue = 1'b1;
                        n_state = S_MED;
                    end
                    default: begin
                        n_res   = r_lastv;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = SB'(div_quot);
                    n_state = S_DONE;
                end
            end
            S_MED: begin
                // issue side: walk every (candidate, other) pair of kept samples in the store
                if (r_issue) begin
                    n_p_valid  = 1'b1;
                    n_p_first  = (r_cj == '0);
                    n_p_endj   = (r_cj == nlast);
                    n_p_endall = (r_cj == nlast) && (r_ci == nlast);
                    if (r_cj == nlast) begin
                        n_cj = '0;
                        n_ci = r_ci + 1'b1;
                        if (r_ci == nlast) begin
                            n_issue = 1'b0;
                        end
                    end else begin
                        n_cj = r_cj + 1'b1;
                    end
                end
                // compare side: rank of the candidate among all kept samples
                if (r_p_valid) begin
                    n_lt = lt_acc;
                    n_le = le_acc;
                    if (r_p_endj) begin
                        if (lt_acc <= klo && klo < le_acc) begin
                            n_lo = rd0;
                        end
                        if (lt_acc <= khi && khi < le_acc) begin
                            n_hi = rd0;
                        end
                    end
                    if (r_p_endall) begin
                        n_state = S_MAVG;
                    end
                end
            end
            S_MAVG: begin
                n_res   = mid_sum[SB:1];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = DATA_W'(r_res);
                    n_out_contrib = CONTRIB_W'(r_count);
                    n_out_ovf     = r_drop;
                    n_count       = '0;
                    n_drop        = 1'b0;
                    n_min         = '1;
                    n_max         = '0;
                    n_sum         = '0;
                    n_state       = S_COLL;
                end
            end
            default: begin
                n_state = S_COLL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLL;
            r_mode      <= MODE_FIRST;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_p_valid   <= 1'b0;
            r_min       <= '1;
            r_max       <= '0;
            r_sum       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_issue     <= n_issue;
            r_p_valid   <= n_p_valid;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lastv       <= n_lastv;
        r_res         <= n_res;
        r_ci          <= n_ci;
        r_cj          <= n_cj;
        r_p_first     <= n_p_first;
        r_p_endj      <= n_p_endj;
        r_p_endall    <= n_p_endall;
        r_lt          <= n_lt;
        r_le          <= n_le;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_out_value   <= n_out_value;
        r_out_contrib <= n_out_contrib;
        r_out_ovf     <= n_out_ovf;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_contrib, r_out_value};
    assign o_m_axis_tuser  = r_out_ovf;

endmodule

`default_nettype wire

// ----- rtl/ovm_chk.sv -----
// ----------------------------------------------------------------------------
// ovm_chk
// port-level checks for the overlap voxel merge block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ovm_chk #(
    parameter int MAX_TILES = ovm_pkg::DEF_MAX_TILES
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             i_s_axis_tlast,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [ovm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic                             o_m_axis_tuser
);

    import ovm_pkg::*;

    logic                 last_xfer;
    logic [CONTRIB_W-1:0] contrib;

    assign last_xfer = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign contrib   = o_m_axis_tdata[DATA_W +: CONTRIB_W];

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // closing sample stops intake until the result is formed
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_xfer |=> !o_s_axis_tready)
        else $error("input accepted right after closing transfer");

    // a dropped sample means the store was full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> contrib == CONTRIB_W'(MAX_TILES))
        else $error("overflow flagged with store not full");

    // a fresh result never shows up on the cycle after the closing transfer
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(last_xfer))
        else $error("result appeared too early");

endmodule

bind overlap_voxel_merge ovm_chk #(.MAX_TILES(MAX_TILES)) u_ovm_chk (.*);

`default_nettype wire

// ----- tb/overlap_voxel_merge_tb.sv -----
// ----------------------------------------------------------------------------
// overlap_voxel_merge_tb
// self-checking bench for the overlap voxel merge block: streams tile samples
// per voxel under every merge mode, predicts each merged result alongside the
// stream and compares it field by field with what the block emits
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_voxel_merge_tb;

    import ovm_pkg::*;

    localparam int TILES         = DEF_MAX_TILES;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 140;

    // codes the block treats like first
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_tile_sample;

    typedef struct packed {
        logic [DATA_W-1:0]    merged;
        logic [CONTRIB_W-1:0] contrib;
        logic                 ovf;
    } t_voxel_result;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [DATA_W-1:0]      i_s_axis_tdata  = '0;
    logic                   i_s_axis_tlast  = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [MODE_W-1:0]      i_cfg_data      = '0;

    overlap_voxel_merge dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // merge state mirrored from the block
    logic [MODE_W-1:0] mode_shadow = MODE_FIRST;
    logic [DATA_W-1:0] tile_store [TILES];
    logic [DATA_W-1:0] low_mark   = '1;
    logic [DATA_W-1:0] high_mark  = '0;
    logic [18:0]       sum_acc    = '0;
    int unsigned       kept       = 0;
    logic              dropped    = 1'b0;

    t_tile_sample  pending_samples [$];
    t_voxel_result merged_due [$];
    int unsigned   mismatch_count = 0;

    t_tile_sample  next_sample;
    logic          drive_valid;
    logic          drive_ready;
    int unsigned   send_wait  = 0;
    int unsigned   recv_wait  = 0;
    bit            send_calm  = 1'b0;
    bit            recv_calm  = 1'b0;
    t_voxel_result seen;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [DATA_W-1:0] median_pick(input int unsigned n);
        logic [DATA_W-1:0] sorted [TILES];
        logic [DATA_W-1:0] key;
        logic [DATA_W:0]   pair;
        int                j;
        for (int i = 0; i < n; i++) begin
            key = tile_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (n % 2 == 1)
            return sorted[n/2];
        pair = sorted[n/2-1] + sorted[n/2];
        return pair[DATA_W:1];
    endfunction

    task automatic absorb_sample(input logic [DATA_W-1:0] v, input logic last);
        t_voxel_result r;
        if (kept < TILES) begin
            tile_store[kept] = v;
            kept++;
            if (v < low_mark)
                low_mark = v;
            if (v > high_mark)
                high_mark = v;
            sum_acc = sum_acc + v;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            case (mode_shadow)
                MODE_MIN:    r.merged = low_mark;
                MODE_MAX:    r.merged = high_mark;
                MODE_MEAN:   r.merged = DATA_W'(sum_acc / kept);
                MODE_MEDIAN: r.merged = median_pick(kept);
                default:     r.merged = tile_store[kept-1];
            endcase
            r.contrib = CONTRIB_W'(kept);
            r.ovf     = dropped;
            merged_due = {merged_due, r};
            low_mark  = '1;
            high_mark = '0;
            sum_acc   = '0;
            kept      = 0;
            dropped   = 1'b0;
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            drive_valid = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_sample(i_s_axis_tdata, i_s_axis_tlast);
                drive_valid = 1'b0;
            end
            if (!drive_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_samples.size() > 0) begin
                    next_sample = pending_samples.pop_front();
                    i_s_axis_tdata <= next_sample.value;
                    i_s_axis_tlast <= next_sample.last;
                    drive_valid = 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 4);
                end
            end
            i_s_axis_tvalid <= drive_valid;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.merged  = o_m_axis_tdata[DATA_W-1:0];
                seen.contrib = o_m_axis_tdata[DATA_W +: CONTRIB_W];
                seen.ovf     = o_m_axis_tuser;
                if (merged_due.size() == 0) begin
                    flag_mismatch("unexpected result, merged_value", seen.merged, 0);
                end else begin
                    if (seen.merged !== merged_due[0].merged)
                        flag_mismatch("merged_value", seen.merged, merged_due[0].merged);
                    if (seen.contrib !== merged_due[0].contrib)
                        flag_mismatch("contributors", seen.contrib, merged_due[0].contrib);
                    if (seen.ovf !== merged_due[0].ovf)
                        flag_mismatch("overflowed", seen.ovf, merged_due[0].ovf);
                    void'(merged_due.pop_front());
                end
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                drive_ready = 1'b0;
            end else begin
                drive_ready = 1'b1;
            end
            i_m_axis_tready <= drive_ready;
        end
    end

    task automatic queue_sample(input logic [DATA_W-1:0] v, input logic last);
        t_tile_sample s;
        s.value = v;
        s.last  = last;
        pending_samples = {pending_samples, s};
    endtask

    // hold the stream until every voxel has been merged and the block is quiet
    task automatic drain_voxels();
        do
            @(posedge i_clk);
        while (pending_samples.size() != 0 || i_s_axis_tvalid || merged_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_shadow = m;
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] base);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return base + DATA_W'($urandom_range(0, 7));
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_random_phase(input int unsigned budget);
        int unsigned       queued;
        int unsigned       n;
        logic [DATA_W-1:0] base;
        queued = 0;
        while (queued < budget) begin
            n    = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            base = DATA_W'($urandom_range(0, 65535));
            for (int k = 0; k < n; k++)
                queue_sample(pick_value(base), k == n - 1);
            queued += n;
        end
    endtask

    logic [MODE_W-1:0] sweep [8] = '{MODE_MIN, MODE_MAX, MODE_MEAN, MODE_MEDIAN,
                                     MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7, MODE_FIRST};

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed voxels
        write_mode(MODE_FIRST);
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h1234, 1'b1);
        drain_voxels();
        write_mode(MODE_MIN);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        drain_voxels();
        write_mode(MODE_MAX);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        drain_voxels();
        // full-scale sum, then a dropped closing sample
        write_mode(MODE_MEAN);
        for (int k = 0; k < TILES + 1; k++)
            queue_sample(16'hFFFF, k == TILES);
        drain_voxels();
        write_mode(MODE_MEDIAN);
        queue_sample(16'h0300, 1'b0);
        queue_sample(16'h0100, 1'b0);
        queue_sample(16'h0200, 1'b1);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFE, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        drain_voxels();
        write_mode(MODE_SPARE_7);
        queue_sample(16'h5A5A, 1'b0);
        queue_sample(16'hA5A5, 1'b1);
        drain_voxels();

        // random voxels, one mode per phase
        for (int p = 0; p < PHASES; p++) begin
            write_mode(p < 8 ? sweep[p] : MODE_W'($urandom_range(0, 7)));
            queue_random_phase(PHASE_ITEMS);
            drain_voxels();
        end

        if (mismatch_count == 0 && merged_due.size() == 0)
            $display("** overlap_voxel_merge: PASSED **");
        else
            $display("** overlap_voxel_merge: FAILED **");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("** overlap_voxel_merge: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
